FILE: sv/pwq_pkg.sv
// pwq_pkg: shared types and constants of the power-of-two quantizer
// used by every module of the block, no dependencies

package pwq_pkg;

  // result field widths
  localparam int CODE_W     = 17;
  localparam int DQ_W       = 49;
  localparam int DQ_MAG_W   = DQ_W - 1;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int EXP_W      = 6;
  localparam int BW_W       = 5;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_EXP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIGN_MODE  = 2'd3;

  // lowest scale exponent honored
  localparam int K_MIN = -16;

  typedef enum logic [1:0] {
    RND_HALF_AWAY = 2'd0,
    RND_FLOOR     = 2'd1,
    RND_CEIL      = 2'd2,
    RND_TRUNC     = 2'd3
  } round_mode_t;

  // code 3 acts as two's complement
  typedef enum logic [1:0] {
    SGN_UNSIGNED = 2'd0,
    SGN_NONPOS   = 2'd1,
    SGN_TWOS     = 2'd2
  } sign_mode_t;

  localparam logic [EXP_W-1:0] RST_SCALE_EXP = 6'd0;
  localparam logic [BW_W-1:0]  RST_BIT_WIDTH = 5'd8;

endpackage

FILE: sv/pwq_cfg.sv
// pwq_cfg: configuration registers and the derived shift and clamp limits
// depends on pwq_pkg

module pwq_cfg #(
  parameter int FRAC_BITS     = 16,
  parameter int MAX_CODE_BITS = 16,
  parameter int SHIFT_W       = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [pwq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwq_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [SHIFT_W-1:0]              shift,
  output pwq_pkg::round_mode_t            round_mode,
  output logic [MAX_CODE_BITS-1:0]        pos_lim,
  output logic [MAX_CODE_BITS-1:0]        neg_lim
);
  import pwq_pkg::*;

  logic [EXP_W-1:0] scale_exp_r;
  round_mode_t      round_mode_r;
  logic [BW_W-1:0]  bit_width_r;
  logic [1:0]       sign_mode_r;

  logic signed [7:0]      k_ext;
  logic signed [7:0]      k_clip;
  logic [7:0]             s_full;
  logic [BW_W-1:0]        n_eff;
  logic [MAX_CODE_BITS-1:0] full;
  logic [MAX_CODE_BITS-1:0] half;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_exp_r  <= RST_SCALE_EXP;
      round_mode_r <= RND_HALF_AWAY;
      bit_width_r  <= RST_BIT_WIDTH;
      sign_mode_r  <= SGN_TWOS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCALE_EXP:  scale_exp_r  <= cfg_data[EXP_W-1:0];
        REG_ROUND_MODE: round_mode_r <= round_mode_t'(cfg_data[1:0]);
        REG_BIT_WIDTH:  bit_width_r  <= cfg_data[BW_W-1:0];
        REG_SIGN_MODE:  sign_mode_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // k clipped to [K_MIN, FRAC_BITS], shift = FRAC_BITS - k
  always_comb begin
    k_ext = $signed({{(8-EXP_W){scale_exp_r[EXP_W-1]}}, scale_exp_r});
    if (k_ext > $signed(8'(FRAC_BITS)))
      k_clip = $signed(8'(FRAC_BITS));
    else if (k_ext < $signed(8'(K_MIN)))
      k_clip = $signed(8'(K_MIN));
    else
      k_clip = k_ext;
    s_full = 8'(FRAC_BITS) - 8'(k_clip);
  end

  assign shift      = s_full[SHIFT_W-1:0];
  assign round_mode = round_mode_r;

  always_comb begin
    if (bit_width_r == '0)
      n_eff = BW_W'(1);
    else if (bit_width_r > BW_W'(MAX_CODE_BITS))
      n_eff = BW_W'(MAX_CODE_BITS);
    else
      n_eff = bit_width_r;
    full = {MAX_CODE_BITS{1'b1}} >> (BW_W'(MAX_CODE_BITS) - n_eff);
    half = MAX_CODE_BITS'(1) << (n_eff - BW_W'(1));
  end

  // magnitude limits for positive and negative results
  always_comb begin
    case (sign_mode_r)
      SGN_UNSIGNED: begin
        pos_lim = full;
        neg_lim = '0;
      end
      SGN_NONPOS: begin
        pos_lim = '0;
        neg_lim = full;
      end
      default: begin
        pos_lim = half - MAX_CODE_BITS'(1);
        neg_lim = half;
      end
    endcase
  end

endmodule

FILE: sv/pwq_round.sv
// pwq_round: sign-magnitude split, scaling shift and rounding of one sample
// depends on pwq_pkg

module pwq_round #(
  parameter int SAMPLE_BITS = 32,
  parameter int SHIFT_W     = 6
) (
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [SHIFT_W-1:0]            shift,
  input  pwq_pkg::round_mode_t          round_mode,
  output logic                          neg,
  output logic [SAMPLE_BITS-1:0]        q
);
  import pwq_pkg::*;

  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] trunc_q;
  logic [SAMPLE_BITS-1:0] rem_mask;
  logic [SAMPLE_BITS-1:0] half_vec;
  logic                   inexact;
  logic                   half_bit;
  logic                   bump;

  always_comb begin
    neg      = sample[SAMPLE_BITS-1];
    // the most negative sample still fits as an unsigned magnitude
    mag      = neg ? (~sample + SAMPLE_BITS'(1)) : sample;
    trunc_q  = mag >> shift;
    rem_mask = ~({SAMPLE_BITS{1'b1}} << shift);
    inexact  = |(mag & rem_mask);
    half_vec = mag >> (shift - SHIFT_W'(1));
    half_bit = (shift != '0) && half_vec[0];
    case (round_mode)
      RND_HALF_AWAY: bump = half_bit;
      RND_FLOOR:     bump = neg && inexact;
      RND_CEIL:      bump = !neg && inexact;
      default:       bump = 1'b0;
    endcase
    q = trunc_q + SAMPLE_BITS'(bump);
  end

endmodule

FILE: sv/pwq_clamp.sv
// pwq_clamp: clamp of the rounded magnitude and exact dequantizing shift
// depends on pwq_pkg

module pwq_clamp #(
  parameter int SAMPLE_BITS   = 32,
  parameter int MAX_CODE_BITS = 16,
  parameter int FRAC_BITS     = 16,
  parameter int SHIFT_W       = 6
) (
  input  logic                                 neg,
  input  logic [SAMPLE_BITS-1:0]               q,
  input  logic [SHIFT_W-1:0]                   shift,
  input  logic [MAX_CODE_BITS-1:0]             pos_lim,
  input  logic [MAX_CODE_BITS-1:0]             neg_lim,
  output logic signed [pwq_pkg::CODE_W-1:0]    quant_code,
  output logic signed [pwq_pkg::DQ_W-1:0]      dequant_value
);
  import pwq_pkg::*;

  localparam int CMP_W = (SAMPLE_BITS > MAX_CODE_BITS) ? SAMPLE_BITS : MAX_CODE_BITS;
  localparam int EXT_W = (MAX_CODE_BITS + 1 > CODE_W) ? MAX_CODE_BITS + 1 : CODE_W;
  localparam int SH_RAW_W = MAX_CODE_BITS + FRAC_BITS - K_MIN;
  localparam int SH_W  = (SH_RAW_W > DQ_W) ? SH_RAW_W : DQ_W;

  logic [MAX_CODE_BITS-1:0] lim;
  logic [MAX_CODE_BITS-1:0] cm;
  logic                     cneg;
  logic [EXT_W-1:0]         cm_ext;
  logic [EXT_W-1:0]         code_ext;
  logic [SH_W-1:0]          sh;
  logic                     ovf;
  logic [DQ_MAG_W-1:0]      dm;
  logic [DQ_W-1:0]          dm_ext;

  always_comb begin
    lim  = neg ? neg_lim : pos_lim;
    cm   = (CMP_W'(q) > CMP_W'(lim)) ? lim : MAX_CODE_BITS'(q);
    cneg = neg && (cm != '0);
    cm_ext   = EXT_W'(cm);
    code_ext = cneg ? (~cm_ext + EXT_W'(1)) : cm_ext;
    quant_code = $signed(code_ext[CODE_W-1:0]);

    // dequantized magnitude saturates at 48 bits
    sh  = SH_W'(cm) << shift;
    ovf = (sh >> DQ_MAG_W) != '0;
    dm  = ovf ? {DQ_MAG_W{1'b1}} : sh[DQ_MAG_W-1:0];
    dm_ext = DQ_W'(dm);
    dequant_value = $signed(cneg ? (~dm_ext + DQ_W'(1)) : dm_ext);
  end

endmodule

FILE: sv/power_of_two_fixed_point_quantizer.sv
// power_of_two_fixed_point_quantizer: top level with input and result registers
// depends on pwq_pkg, pwq_cfg, pwq_round, pwq_clamp
//
// Quantizes one signed fixed-point sample per request: scales it by 2^k,
// rounds by the selected mode, clamps to an N-bit code range and returns the
// code together with code / 2^k in the sample's fixed-point format.
// Channels: in_* carries the sample, out_* the code and dequantized value,
// cfg_* writes one register per request (0 exponent, 1 round mode,
// 2 bit width, 3 sign mode); cfg_ready is always high and writes are
// expected only while no request is in flight.
// The sample is taken into one input register, then rounding, clamp and shift
// logic feed the result register, which drives out_tdata and out_tvalid.
// Throughput is one request per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; in_tready drops only when both are full.
// Reset empties both registers and loads exponent 0, round half away from
// zero, bit width 8 and two's complement.

module power_of_two_fixed_point_quantizer #(
  parameter int FRAC_BITS     = 16,
  parameter int MAX_CODE_BITS = 16,
  parameter int SAMPLE_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [SAMPLE_BITS-1:0] sample, rest zero
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [16:0] quant_code, [65:17] dequant_value, [71:66] zero
  output logic [((pwq_pkg::CODE_W+pwq_pkg::DQ_W+7)/8)*8-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pwq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwq_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pwq_pkg::*;

  localparam int SHIFT_W = $clog2(FRAC_BITS - K_MIN + 1);
  localparam int OUT_W   = ((CODE_W + DQ_W + 7) / 8) * 8;

  logic [SHIFT_W-1:0]       shift;
  round_mode_t              round_mode;
  logic [MAX_CODE_BITS-1:0] pos_lim;
  logic [MAX_CODE_BITS-1:0] neg_lim;

  logic                          s1_valid_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic                          out_valid_r;
  logic signed [CODE_W-1:0]      code_r;
  logic signed [DQ_W-1:0]        dq_r;

  logic                          out_free;
  logic                          s1_adv;
  logic                          neg;
  logic [SAMPLE_BITS-1:0]        q;
  logic signed [CODE_W-1:0]      code_nxt;
  logic signed [DQ_W-1:0]        dq_nxt;

  assign cfg_ready = 1'b1;

  pwq_cfg #(
    .FRAC_BITS    (FRAC_BITS),
    .MAX_CODE_BITS(MAX_CODE_BITS),
    .SHIFT_W      (SHIFT_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .shift     (shift),
    .round_mode(round_mode),
    .pos_lim   (pos_lim),
    .neg_lim   (neg_lim)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_sample_r <= $signed(in_tdata[SAMPLE_BITS-1:0]);
    end
  end

  pwq_round #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .SHIFT_W    (SHIFT_W)
  ) u_round (
    .sample    (s1_sample_r),
    .shift     (shift),
    .round_mode(round_mode),
    .neg       (neg),
    .q         (q)
  );

  pwq_clamp #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_CODE_BITS(MAX_CODE_BITS),
    .FRAC_BITS    (FRAC_BITS),
    .SHIFT_W      (SHIFT_W)
  ) u_clamp (
    .neg          (neg),
    .q            (q),
    .shift        (shift),
    .pos_lim      (pos_lim),
    .neg_lim      (neg_lim),
    .quant_code   (code_nxt),
    .dequant_value(dq_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      code_r <= code_nxt;
      dq_r   <= dq_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - CODE_W - DQ_W)'(0), dq_r, code_r};

  // a request in the input register moves on whenever the result side is free
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("input register request did not reach the result register");

  // an accepted request is always held in the input register next cycle
  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s1_valid_r)
    else $error("accepted request lost");

  // code and dequantized value carry the same sign
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> code_r[CODE_W-1] == dq_r[DQ_W-1])
    else $error("code and dequantized value disagree in sign");

  // a zero code dequantizes to zero
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (code_r == '0) |-> dq_r == '0)
    else $error("zero code gave nonzero dequantized value");

endmodule
